[hdl/cga_pkg.sv]
// constants and segment tables for the cjk glyph address generator
// used by cjk_glyph_address_generator_top; no dependencies
package cga_pkg;

  localparam int unsigned CodeW    = 16;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned IdxW     = 15;
  localparam int unsigned HeightW  = 8;
  localparam int unsigned RowsW    = 6;
  localparam int unsigned BytesW   = RowsW + HeightW;
  localparam int unsigned ProdW    = BytesW + IdxW;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned Gb2312Segs = 20;

  localparam logic [7:0] GbkRow    = 8'd191;
  localparam logic [7:0] Gb2312Row = 8'd94;
  localparam logic [7:0] GbkHiMin  = 8'h81;
  localparam logic [7:0] GbkLoMin  = 8'h40;
  localparam logic [7:0] Gb2312Min = 8'hA1;
  localparam logic [7:0] Gb2312HiMax = 8'hF7;
  localparam logic [7:0] ByteMax   = 8'hFF;

  // gbk table segments
  localparam logic [CodeW-1:0] GbkSeg0Hi = 16'h047F;
  localparam logic [CodeW-1:0] GbkSeg1Lo = 16'h2000;
  localparam logic [CodeW-1:0] GbkSeg1Hi = 16'h33FF;
  localparam logic [CodeW-1:0] GbkSeg2Lo = 16'h4E00;
  localparam logic [CodeW-1:0] GbkSeg2Hi = 16'h9FFF;
  localparam logic [CodeW-1:0] GbkSeg3Lo = 16'hF900;
  localparam logic [AddrW-1:0] GbkSub1 = 32'd14080;
  localparam logic [AddrW-1:0] GbkSub2 = 32'd27392;
  localparam logic [AddrW-1:0] GbkSub3 = 32'd68608;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegCharsetMode = 8'd0;
  localparam logic [CfgIdxW-1:0] RegGlyphHeight = 8'd1;
  localparam logic [CfgIdxW-1:0] RegGlyphBase   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegTableBase   = 8'd3;

  localparam logic       ModeGbk    = 1'b0;
  localparam logic       ModeGb2312 = 1'b1;
  localparam logic       CmdGlyph   = 1'b0;
  localparam logic       CmdTable   = 1'b1;

  typedef logic [CodeW-1:0] seg_arr_t [Gb2312Segs];
  typedef logic [AddrW-1:0] sub_arr_t [Gb2312Segs];

  localparam seg_arr_t Gb2312Lo = '{
    16'h00A4, 16'h0391, 16'h2014, 16'h2103, 16'h2460, 16'h3000, 16'h3220,
    16'h4E00, 16'h7E3B, 16'h8D1D, 16'h8F66, 16'h9274, 16'h9A6C, 16'h9C7C,
    16'h9E1F, 16'hE000, 16'hE766, 16'hFE31, 16'hFF01, 16'hFFE0
  };
  localparam seg_arr_t Gb2312Hi = '{
    16'h02C9, 16'h0451, 16'h203B, 16'h2312, 16'h2642, 16'h3129, 16'h3229,
    16'h7DAE, 16'h8C98, 16'h8ECE, 16'h91DC, 16'h99A8, 16'h9B54, 16'h9CE2,
    16'h9FA0, 16'hE233, 16'hE814, 16'hFE44, 16'hFF5E, 16'hFFFF
  };
  localparam sub_arr_t Gb2312Sub = '{
    32'd328,   32'd726,   32'd14938, 32'd15336, 32'd16002, 32'd20988, 32'd21480,
    32'd35732, 32'd36012, 32'd36276, 32'd36578, 32'd36880, 32'd37270, 32'd37860,
    32'd38492, 32'd71450, 32'd74110, 32'd85430, 32'd85806, 32'd86064
  };

endpackage

[hdl/cjk_glyph_address_generator_top.sv]
// cjk glyph address generator: three-stage pipeline from code to byte address
// depends on cga_pkg
//
// usage:
// - an item (cmd_i, code_i) is taken at each rising edge with start_i high;
//   busy_o is always low, so an item may enter in every cycle
// - cmd 0: code_i is a gbk or gb2312 double-byte code (charset_mode); the
//   result is glyph_base + ceil(h/8)*h * zone index
// - cmd 1: code_i is a utf-16 unit; the result is table_base plus the
//   offset of its 2-byte entry in the conversion table
// - each result shows on hit_o / address_o for one cycle with valid_o high,
//   after its item has passed stages 1, 2 and 3; address_o is 0 on a miss
// - stage 1 decodes ranges and forms the index and table offset, stage 2
//   multiplies index by glyph size, stage 3 adds the base
// - throughput is one item per cycle; the receiver cannot stall, and
//   results leave in item order
// - configuration writes use cfg_valid_i / cfg_ready_o (always ready) with
//   cfg_index_i and cfg_data_i; an unknown index is ignored; write only idle
// - reset (rst_ni low, asynchronous) empties the pipeline and restores
//   charset_mode 0, glyph_height 16, glyph_base 6, table_base 0
module cjk_glyph_address_generator_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cmd_i,
  input  logic [cga_pkg::CodeW-1:0]    code_i,
  output logic                         valid_o,
  output logic                         hit_o,
  output logic [cga_pkg::AddrW-1:0]    address_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cga_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cga_pkg::AddrW-1:0]    cfg_data_i
);

  // configuration registers
  logic                               charset_mode_q;
  logic [cga_pkg::HeightW-1:0]        glyph_height_q;
  logic [cga_pkg::AddrW-1:0]          glyph_base_q;
  logic [cga_pkg::AddrW-1:0]          table_base_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charset_mode_q <= cga_pkg::ModeGbk;
      glyph_height_q <= 8'd16;
      glyph_base_q   <= 32'd6;
      table_base_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cga_pkg::RegCharsetMode: charset_mode_q <= cfg_data_i[0];
        cga_pkg::RegGlyphHeight: glyph_height_q <= cfg_data_i[cga_pkg::HeightW-1:0];
        cga_pkg::RegGlyphBase:   glyph_base_q   <= cfg_data_i;
        cga_pkg::RegTableBase:   table_base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: range checks, index, table offset
  logic [7:0]                  hi_byte, lo_byte;
  logic                        glyph_ok, table_ok;
  logic [cga_pkg::IdxW-1:0]    idx_d;
  logic [cga_pkg::AddrW-1:0]   twice, toff_d;
  logic [cga_pkg::RowsW-1:0]   rows;
  logic [cga_pkg::BytesW-1:0]  bytes_d;

  assign hi_byte = code_i[15:8];
  assign lo_byte = code_i[7:0];
  assign twice   = {{(cga_pkg::AddrW-cga_pkg::CodeW-1){1'b0}}, code_i, 1'b0};

  always_comb begin
    logic [7:0] hrel, lrel;
    logic [15:0] rowprod;
    hrel = '0;
    lrel = '0;
    rowprod = '0;
    if (charset_mode_q == cga_pkg::ModeGbk) begin
      glyph_ok = (hi_byte >= cga_pkg::GbkHiMin) && (hi_byte != cga_pkg::ByteMax) &&
                 (lo_byte >= cga_pkg::GbkLoMin) && (lo_byte != cga_pkg::ByteMax);
      hrel    = hi_byte - cga_pkg::GbkHiMin;
      lrel    = lo_byte - cga_pkg::GbkLoMin;
      rowprod = {8'd0, hrel} * {8'd0, cga_pkg::GbkRow};
    end else begin
      glyph_ok = (hi_byte >= cga_pkg::Gb2312Min) && (hi_byte <= cga_pkg::Gb2312HiMax) &&
                 (lo_byte >= cga_pkg::Gb2312Min) && (lo_byte != cga_pkg::ByteMax);
      hrel    = hi_byte - cga_pkg::Gb2312Min;
      lrel    = lo_byte - cga_pkg::Gb2312Min;
      rowprod = {8'd0, hrel} * {8'd0, cga_pkg::Gb2312Row};
    end
    idx_d = cga_pkg::IdxW'(rowprod + {8'd0, lrel});
  end

  always_comb begin
    table_ok = 1'b0;
    toff_d   = '0;
    if (charset_mode_q == cga_pkg::ModeGbk) begin
      if (code_i <= cga_pkg::GbkSeg0Hi) begin
        table_ok = 1'b1;
        toff_d   = twice;
      end else if (code_i >= cga_pkg::GbkSeg1Lo && code_i <= cga_pkg::GbkSeg1Hi) begin
        table_ok = 1'b1;
        toff_d   = twice - cga_pkg::GbkSub1;
      end else if (code_i >= cga_pkg::GbkSeg2Lo && code_i <= cga_pkg::GbkSeg2Hi) begin
        table_ok = 1'b1;
        toff_d   = twice - cga_pkg::GbkSub2;
      end else if (code_i >= cga_pkg::GbkSeg3Lo) begin
        table_ok = 1'b1;
        toff_d   = twice - cga_pkg::GbkSub3;
      end
    end else begin
      // segments are disjoint, so the compares run side by side
      for (int k = 0; k < cga_pkg::Gb2312Segs; k++) begin
        if (code_i >= cga_pkg::Gb2312Lo[k] && code_i <= cga_pkg::Gb2312Hi[k]) begin
          table_ok = 1'b1;
          toff_d   = twice - cga_pkg::Gb2312Sub[k];
        end
      end
    end
  end

  // bytes per glyph: ceil(h/8) rows of h bytes
  assign rows    = cga_pkg::RowsW'(({1'b0, glyph_height_q} + 9'd7) >> 3);
  assign bytes_d = {{(cga_pkg::BytesW-cga_pkg::RowsW){1'b0}}, rows} *
                   {{(cga_pkg::BytesW-cga_pkg::HeightW){1'b0}}, glyph_height_q};

  logic                        v1_q, cmd1_q, hit1_q;
  logic [cga_pkg::IdxW-1:0]    idx1_q;
  logic [cga_pkg::AddrW-1:0]   toff1_q;
  logic [cga_pkg::BytesW-1:0]  bytes1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd1_q   <= cmd_i;
    hit1_q   <= (cmd_i == cga_pkg::CmdGlyph) ? glyph_ok : table_ok;
    idx1_q   <= idx_d;
    toff1_q  <= toff_d;
    bytes1_q <= bytes_d;
  end

  // ---------------- stage 2: glyph size times index
  logic                        v2_q, cmd2_q, hit2_q;
  logic [cga_pkg::ProdW-1:0]   prod2_q;
  logic [cga_pkg::AddrW-1:0]   toff2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd2_q  <= cmd1_q;
    hit2_q  <= hit1_q;
    prod2_q <= {{(cga_pkg::ProdW-cga_pkg::BytesW){1'b0}}, bytes1_q} *
               {{(cga_pkg::ProdW-cga_pkg::IdxW){1'b0}}, idx1_q};
    toff2_q <= toff1_q;
  end

  // ---------------- stage 3: add base, zero on miss
  logic                        v3_q, hit3_q;
  logic [cga_pkg::AddrW-1:0]   addr3_d, addr3_q;

  always_comb begin
    if (!hit2_q) begin
      addr3_d = '0;
    end else if (cmd2_q == cga_pkg::CmdTable) begin
      addr3_d = table_base_q + toff2_q;
    end else begin
      addr3_d = glyph_base_q + {{(cga_pkg::AddrW-cga_pkg::ProdW){1'b0}}, prod2_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit3_q  <= hit2_q;
    addr3_q <= addr3_d;
  end

  assign valid_o   = v3_q;
  assign hit_o     = hit3_q;
  assign address_o = addr3_q;

  // ---------------- assertions
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, 3))
    else $error("result without an item three cycles before");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !hit_o) |-> (address_o == '0))
    else $error("miss with nonzero address");

  a_pipe_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |=> v2_q ##1 v3_q)
    else $error("item lost in pipeline");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && hit1_q && cmd1_q == cga_pkg::CmdGlyph) |-> (idx1_q <= 15'd24065))
    else $error("glyph index out of range");

endmodule

[sim/cga_checker.sv]
// checker for cjk_glyph_address_generator_top: keeps its own copy of the registers,
// predicts hit and address of every accepted item and compares results in order
// depends on cga_pkg
module cga_checker
  import cga_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               cmd_i,
  input  logic [CodeW-1:0]   code_i,
  input  logic               valid_i,
  input  logic               hit_i,
  input  logic [AddrW-1:0]   address_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o,
  output int unsigned        hit_cnt_o
);

  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] address;
  } glyph_result_t;

  glyph_result_t expected_q[$];
  glyph_result_t oldest;

  logic               mode_q;
  logic [HeightW-1:0] height_q;
  logic [AddrW-1:0]   glyph_base_q;
  logic [AddrW-1:0]   table_base_q;

  function automatic glyph_result_t calc_glyph_address(input logic cmd,
                                                       input logic [CodeW-1:0] code);
    glyph_result_t res;
    logic [31:0] hi_w, lo_w, zone_idx, glyph_bytes, height_w, twice;
    res = '0;
    hi_w = {24'd0, code[15:8]};
    lo_w = {24'd0, code[7:0]};
    height_w = {24'd0, height_q};
    twice = {15'd0, code, 1'b0};
    if (cmd == CmdGlyph) begin
      if (mode_q == ModeGbk) begin
        res.hit = hi_w >= 32'(GbkHiMin) && hi_w != 32'(ByteMax) &&
                  lo_w >= 32'(GbkLoMin) && lo_w != 32'(ByteMax);
        zone_idx = (hi_w - 32'(GbkHiMin)) * 32'(GbkRow) + (lo_w - 32'(GbkLoMin));
      end else begin
        res.hit = hi_w >= 32'(Gb2312Min) && hi_w <= 32'(Gb2312HiMax) &&
                  lo_w >= 32'(Gb2312Min) && lo_w != 32'(ByteMax);
        zone_idx = (hi_w - 32'(Gb2312Min)) * 32'(Gb2312Row) + (lo_w - 32'(Gb2312Min));
      end
      // bytes per glyph: one byte per 8 columns, rounded up, times rows
      glyph_bytes = ((height_w + 32'd7) / 32'd8) * height_w;
      if (res.hit) res.address = glyph_base_q + glyph_bytes * zone_idx;
    end else if (mode_q == ModeGbk) begin
      res.hit = 1'b1;
      if (code <= GbkSeg0Hi) res.address = table_base_q + twice;
      else if (code >= GbkSeg1Lo && code <= GbkSeg1Hi)
        res.address = table_base_q + twice - GbkSub1;
      else if (code >= GbkSeg2Lo && code <= GbkSeg2Hi)
        res.address = table_base_q + twice - GbkSub2;
      else if (code >= GbkSeg3Lo) res.address = table_base_q + twice - GbkSub3;
      else res.hit = 1'b0;
    end else begin
      for (int k = 0; k < Gb2312Segs; k++) begin
        if (!res.hit && code >= Gb2312Lo[k] && code <= Gb2312Hi[k]) begin
          res.hit = 1'b1;
          res.address = table_base_q + twice - Gb2312Sub[k];
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q = ModeGbk;
      height_q = 8'd16;
      glyph_base_q = 32'd6;
      table_base_q = 32'd0;
      expected_q.delete();
      mismatch_cnt_o = 0;
      checked_o = 0;
      hit_cnt_o = 0;
    end else begin
      if (valid_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no item outstanding: hit %0b address %08h", hit_i, address_i);
          mismatch_cnt_o++;
        end else begin
          oldest = expected_q.pop_front();
          checked_o++;
          if (oldest.hit) hit_cnt_o++;
          if (hit_i !== oldest.hit) begin
            $error("hit mismatch: expected %0b, got %0b", oldest.hit, hit_i);
            mismatch_cnt_o++;
          end
          if (address_i !== oldest.address) begin
            $error("address mismatch: expected %08h, got %08h", oldest.address, address_i);
            mismatch_cnt_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegCharsetMode: mode_q = cfg_data_i[0];
          RegGlyphHeight: height_q = cfg_data_i[HeightW-1:0];
          RegGlyphBase:   glyph_base_q = cfg_data_i;
          RegTableBase:   table_base_q = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_q.push_back(calc_glyph_address(cmd_i, code_i));
    end
    pending_o = expected_q.size();
  end

endmodule

[sim/tb.sv]
// testbench top for cjk_glyph_address_generator_top: clock, reset, directed and
// random items under several register settings, verdict at the end
// depends on cga_pkg, cga_checker and the block itself
module tb;
  import cga_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned DrainCycles  = 8;
  localparam int unsigned RandomPhases = 11;
  localparam int unsigned PhaseItems   = 135;
  localparam logic [CfgIdxW-1:0] RegFirstUnused = RegTableBase + 8'd1;

  localparam logic [16:0] GbkProbes [18] = '{
    {CmdGlyph, 16'h8140}, {CmdGlyph, 16'hFEFE}, {CmdGlyph, 16'h817F},
    {CmdGlyph, 16'h8040}, {CmdGlyph, 16'hFF40}, {CmdGlyph, 16'h813F},
    {CmdGlyph, 16'h81FF}, {CmdTable, 16'h0000}, {CmdTable, 16'h047F},
    {CmdTable, 16'h0480}, {CmdTable, 16'h2000}, {CmdTable, 16'h33FF},
    {CmdTable, 16'h4E00}, {CmdTable, 16'h9FFF}, {CmdTable, 16'hF8FF},
    {CmdTable, 16'hF900}, {CmdTable, 16'hFFFF}, {CmdGlyph, 16'hFFFF}
  };
  localparam logic [16:0] Gb2312Probes [8] = '{
    {CmdGlyph, 16'hA1A1}, {CmdGlyph, 16'hF7FE}, {CmdGlyph, 16'hF8A1},
    {CmdGlyph, 16'hA0A1}, {CmdGlyph, 16'hA1FF}, {CmdTable, 16'h00A4},
    {CmdTable, 16'h00A3}, {CmdTable, 16'hFFFF}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               cmd_i = 1'b0;
  logic [CodeW-1:0]   code_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [AddrW-1:0]   cfg_data_i = '0;
  logic               busy_o, valid_o, hit_o, cfg_ready_o;
  logic [AddrW-1:0]   address_o;

  int unsigned mismatch_cnt, pending, checked_cnt, hit_cnt;
  int unsigned item_cnt = 0;
  int unsigned setting_cnt = 0;
  int unsigned cycle_cnt = 0;

  cjk_glyph_address_generator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .code_i      (code_i),
    .valid_o     (valid_o),
    .hit_o       (hit_o),
    .address_o   (address_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  cga_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .cmd_i          (cmd_i),
    .code_i         (code_i),
    .valid_i        (valid_o),
    .hit_i          (hit_o),
    .address_i      (address_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .checked_o      (checked_cnt),
    .hit_cnt_o      (hit_cnt)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("cjk_glyph_address_generator_top test failed");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CodeW-1:0] random_code(input logic cmd, input logic mode);
    int unsigned roll, k;
    logic [7:0] hi_b, lo_b;
    logic [CodeW-1:0] anchor;
    roll = $urandom_range(0, 99);
    if (cmd == CmdGlyph) begin
      if (roll < 80) begin
        if (mode == ModeGbk) begin
          hi_b = 8'($urandom_range(GbkHiMin, ByteMax - 8'd1));
          lo_b = 8'($urandom_range(GbkLoMin, ByteMax - 8'd1));
        end else begin
          hi_b = 8'($urandom_range(Gb2312Min, Gb2312HiMax));
          lo_b = 8'($urandom_range(Gb2312Min, ByteMax - 8'd1));
        end
        return {hi_b, lo_b};
      end
      return CodeW'($urandom());
    end
    // table lookups: half of them land within two codes of a segment bound
    if (roll < 50) begin
      if (mode == ModeGbk) begin
        case ($urandom_range(0, 5))
          0: anchor = GbkSeg0Hi;
          1: anchor = GbkSeg1Lo;
          2: anchor = GbkSeg1Hi;
          3: anchor = GbkSeg2Lo;
          4: anchor = GbkSeg2Hi;
          default: anchor = GbkSeg3Lo;
        endcase
      end else begin
        k = $urandom_range(0, Gb2312Segs - 1);
        anchor = $urandom_range(0, 1) ? Gb2312Lo[k] : Gb2312Hi[k];
      end
      lo_b = 8'($urandom_range(0, 4));
      return anchor + {8'd0, lo_b} - 16'd2;
    end
    return CodeW'($urandom());
  endfunction

  task automatic send_code(input logic cmd, input logic [CodeW-1:0] code);
    logic taken;
    start_i <= 1'b1;
    cmd_i <= cmd;
    code_i <= code;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end
    item_cnt++;
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // every item gives a result, so an empty scoreboard means an empty pipeline
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AddrW-1:0] data);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
  endtask

  task automatic apply_setting(input logic mode, input logic [HeightW-1:0] height,
                               input logic [AddrW-1:0] gbase, input logic [AddrW-1:0] tbase);
    logic [AddrW-1:0] noise;
    drain();
    // upper data bits are random, the block must mask them off
    noise = $urandom();
    noise[0] = mode;
    write_reg(RegCharsetMode, noise);
    noise = $urandom();
    noise[HeightW-1:0] = height;
    write_reg(RegGlyphHeight, noise);
    write_reg(RegGlyphBase, gbase);
    write_reg(RegTableBase, tbase);
    if ($urandom_range(0, 1))
      write_reg(CfgIdxW'($urandom_range(RegFirstUnused, 8'hFF)), $urandom());
    cfg_valid_i <= 1'b0;
    setting_cnt++;
  endtask

  task automatic random_phase(input logic mode);
    logic steady;
    logic cmd;
    steady = ($urandom_range(0, 3) == 0);
    for (int n = 0; n < PhaseItems; n++) begin
      cmd = 1'($urandom_range(0, 1));
      send_code(cmd, random_code(cmd, mode));
      if ($urandom_range(0, 99) == 0) drain();
      else if (!steady) hold_off(pick_gap());
    end
  endtask

  initial begin
    logic mode;
    logic [HeightW-1:0] height;
    logic [AddrW-1:0] gbase, tbase;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: gbk, height 16, glyph base 6, table base 0
    foreach (GbkProbes[i]) begin
      send_code(GbkProbes[i][16], GbkProbes[i][15:0]);
      hold_off(pick_gap());
    end
    apply_setting(ModeGb2312, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    foreach (Gb2312Probes[i]) begin
      send_code(Gb2312Probes[i][16], Gb2312Probes[i][15:0]);
      hold_off(pick_gap());
    end

    // zero height collapses every glyph onto the base
    apply_setting(ModeGbk, 8'd0, 32'd0, 32'd0);
    random_phase(ModeGbk);
    for (int p = 0; p < RandomPhases; p++) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0: height = 8'd0;
        1: height = 8'd1;
        2: height = 8'hFF;
        3: height = 8'd8;
        4: height = 8'd9;
        default: height = HeightW'($urandom_range(1, 255));
      endcase
      case ($urandom_range(0, 3))
        0: gbase = 32'd0;
        1: gbase = 32'hFFFF_FFFF;
        default: gbase = $urandom();
      endcase
      case ($urandom_range(0, 3))
        0: tbase = 32'd0;
        1: tbase = 32'hFFFF_FFFF;
        default: tbase = $urandom();
      endcase
      apply_setting(mode, height, gbase, tbase);
      random_phase(mode);
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d items under %0d register settings, both charsets and commands",
             item_cnt, setting_cnt);
    $display("%0d results compared, %0d of them hits", checked_cnt, hit_cnt);
    if (mismatch_cnt == 0) begin
      $display("cjk_glyph_address_generator_top test passed");
    end else begin
      $display("cjk_glyph_address_generator_top test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/cga_pkg.sv
hdl/cjk_glyph_address_generator_top.sv
sim/cga_checker.sv
sim/tb.sv
